FILE: sv/cri_pkg.sv
// Package for the card reader interface: item and result types, event codes,
// order bytes, mode-line and pulse bit positions.
// No dependencies.
package cri_pkg;

    // event codes carried in tuser
    typedef enum logic [2:0] {
        OP_COMMAND = 3'd0,
        OP_SEND    = 3'd1,
        OP_RETIRE  = 3'd2,
        OP_FEED    = 3'd3,
        OP_FREE    = 3'd4,
        OP_ERROR   = 3'd5
    } t_opcode;

    // known order bytes
    localparam logic [7:0] ORD_READ      = 8'h40;
    localparam logic [7:0] ORD_NORMAL1   = 8'h21;
    localparam logic [7:0] ORD_NORMAL2   = 8'h01;
    localparam logic [7:0] ORD_MIXED1    = 8'h24;
    localparam logic [7:0] ORD_MIXED2    = 8'h04;
    localparam logic [7:0] ORD_BYPASS    = 8'h20;
    localparam logic [7:0] ORD_BIN_A1    = 8'ha1;
    localparam logic [7:0] ORD_BIN_81    = 8'h81;
    localparam logic [7:0] ORD_BIN_A4    = 8'ha4;
    localparam logic [7:0] ORD_BIN_84    = 8'h84;
    localparam logic [7:0] ORD_BIN_BYP   = 8'ha0;
    localparam logic [7:0] ORD_BIN_AC    = 8'hac;
    localparam logic [7:0] ORD_STATUS    = 8'h44;
    localparam logic [7:0] ORD_RST_ERR   = 8'h47;
    localparam logic [7:0] ORD_REJECT    = 8'h48;
    localparam logic [7:0] ORD_OC        = 8'h0c;

    // mode line bit positions
    localparam int LINE_N1  = 0;
    localparam int LINE_N2  = 1;
    localparam int LINE_MI1 = 2;
    localparam int LINE_MI2 = 3;
    localparam int LINE_BYP = 4;

    // pulse bit positions
    localparam int PULSE_CMD    = 0;
    localparam int PULSE_CLOCK  = 1;
    localparam int PULSE_REJECT = 2;
    localparam int PULSE_FEED   = 3;
    localparam int PULSE_END    = 4;

    localparam int ANOMALY_OUT_BITS = 16;
    localparam int TDATA_IN_BITS    = 16;
    localparam int TDATA_OUT_BITS   = 48;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] command_byte;
        logic [7:0] data_byte;
        logic       end_flag;
    } t_item;

    typedef struct packed {
        logic                        char_strobe;
        logic [7:0]                  data_lines;
        logic                        end_of_card;
        logic                        reader_free;
        logic                        error_line;
        logic                        read_mode;
        logic                        mode_valid;
        logic [4:0]                  mode_lines;
        logic                        read_pending;
        logic [ANOMALY_OUT_BITS-1:0] anomaly_count;
        logic [4:0]                  pulses;
    } t_result;

    // true for the sixteen decoded order bytes
    function automatic logic order_known(input logic [7:0] c);
        logic k;
        k = 1'b0;
        unique case (c)
            ORD_READ, ORD_NORMAL1, ORD_NORMAL2, ORD_MIXED1, ORD_MIXED2, ORD_BYPASS,
            ORD_BIN_A1, ORD_BIN_81, ORD_BIN_A4, ORD_BIN_84, ORD_BIN_BYP, ORD_BIN_AC,
            ORD_STATUS, ORD_RST_ERR, ORD_REJECT, ORD_OC: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/cri_in_stage.sv
// Input register of the card reader interface: holds one item until the
// state stage takes it. Depends on cri_pkg.
module cri_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cri_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_take,
    output logic           o_valid,
    output cri_pkg::t_item o_item
);
    import cri_pkg::*;

    logic   r_valid;
    t_item  r_item;
    logic   n_valid;

    // register empties when taken, refills in the same cycle
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload load
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/cri_core.sv
// Reader line state and event decode of the card reader interface: updates
// the lines on each item and forms its result. Depends on cri_pkg.
module cri_core #(
    parameter int ANOMALY_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  cri_pkg::t_item   i_item,
    input  logic             i_not_operable,
    output cri_pkg::t_result o_result
);
    import cri_pkg::*;

    logic                    r_strobe, n_strobe;
    logic [7:0]              r_data, n_data;
    logic                    r_end, n_end;
    logic                    r_free, n_free;
    logic                    r_error, n_error;
    logic                    r_mode, n_mode;
    logic                    r_mode_valid, n_mode_valid;
    logic [4:0]              r_lines, n_lines;
    logic                    r_pending, n_pending;
    logic [ANOMALY_BITS-1:0] r_anomaly, n_anomaly;
    logic [4:0]              pulses;
    logic [4:0]              sel_line;
    logic                    sel_binary;
    logic [31:0]             anomaly_ext;

    // mode-select decode of the order byte
    always_comb begin
        sel_line   = '0;
        sel_binary = 1'b0;
        unique case (i_item.command_byte)
            ORD_NORMAL1: sel_line[LINE_N1]  = 1'b1;
            ORD_NORMAL2: sel_line[LINE_N2]  = 1'b1;
            ORD_MIXED1:  sel_line[LINE_MI1] = 1'b1;
            ORD_MIXED2:  sel_line[LINE_MI2] = 1'b1;
            ORD_BYPASS, ORD_BIN_BYP: begin
                sel_line[LINE_BYP] = 1'b1;
                sel_binary         = 1'b1;
            end
            default: sel_line = '0;
        endcase
    end

    // next line state and pulses for one event
    always_comb begin
        n_strobe     = r_strobe;
        n_data       = r_data;
        n_end        = r_end;
        n_free       = r_free;
        n_error      = r_error;
        n_mode       = r_mode;
        n_mode_valid = r_mode_valid;
        n_lines      = r_lines;
        n_pending    = r_pending;
        n_anomaly    = r_anomaly;
        pulses       = '0;
        unique case (t_opcode'(i_item.opcode))
            OP_COMMAND: begin
                pulses[PULSE_CMD] = 1'b1;
                if (!order_known(i_item.command_byte)) begin
                    n_anomaly = r_anomaly + ANOMALY_BITS'(1);
                end
                n_lines = sel_line;
                if (sel_line != '0) begin
                    n_mode              = sel_binary;
                    n_mode_valid        = 1'b1;
                    pulses[PULSE_CLOCK] = 1'b1;
                end
                unique case (i_item.command_byte)
                    ORD_READ, ORD_NORMAL1, ORD_NORMAL2, ORD_MIXED1, ORD_MIXED2,
                    ORD_BYPASS: begin
                        n_end     = 1'b0;
                        n_pending = 1'b1;
                    end
                    ORD_RST_ERR: n_error = 1'b0;
                    ORD_REJECT:  pulses[PULSE_REJECT] = 1'b1;
                    default:     n_pending = r_pending;
                endcase
            end
            OP_SEND: begin
                n_strobe          = 1'b1;
                n_data            = i_item.data_byte;
                n_end             = i_item.end_flag;
                n_free            = 1'b0;
                pulses[PULSE_END] = i_item.end_flag;
            end
            OP_RETIRE: n_strobe = 1'b0;
            OP_FEED:   pulses[PULSE_FEED] = !i_not_operable;
            OP_FREE:   n_free = 1'b1;
            OP_ERROR:  n_error = 1'b1;
            default:   pulses = '0;
        endcase
    end

    // control state update on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= 1'b0;
            r_data       <= '0;
            r_end        <= 1'b0;
            r_free       <= 1'b0;
            r_error      <= 1'b0;
            r_mode       <= 1'b0;
            r_mode_valid <= 1'b0;
            r_lines      <= '0;
            r_pending    <= 1'b0;
            r_anomaly    <= '0;
        end else if (i_fire) begin
            r_strobe     <= n_strobe;
            r_data       <= n_data;
            r_end        <= n_end;
            r_free       <= n_free;
            r_error      <= n_error;
            r_mode       <= n_mode;
            r_mode_valid <= n_mode_valid;
            r_lines      <= n_lines;
            r_pending    <= n_pending;
            r_anomaly    <= n_anomaly;
        end
    end

    // result shows the lines after the event
    assign anomaly_ext = 32'(n_anomaly);

    always_comb begin
        o_result.char_strobe   = n_strobe;
        o_result.data_lines    = n_data;
        o_result.end_of_card   = n_end;
        o_result.reader_free   = n_free;
        o_result.error_line    = n_error;
        o_result.read_mode     = n_mode;
        o_result.mode_valid    = n_mode_valid;
        o_result.mode_lines    = n_lines;
        o_result.read_pending  = n_pending;
        o_result.anomaly_count = anomaly_ext[ANOMALY_OUT_BITS-1:0];
        o_result.pulses        = pulses;
    end

endmodule

FILE: sv/cri_out_stage.sv
// Result register of the card reader interface: packs a result into the
// master stream word and holds it until taken. Depends on cri_pkg.
module cri_out_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  cri_pkg::t_result                     i_result,
    output logic                                 o_room,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [cri_pkg::TDATA_OUT_BITS-1:0]   o_data
);
    import cri_pkg::*;

    logic                      r_valid;
    logic [TDATA_OUT_BITS-1:0] r_data;
    logic [TDATA_OUT_BITS-1:0] n_data;

    // room when empty or the held item leaves this cycle
    assign o_room = !r_valid || i_ready;

    // field packing, first field in the low bits
    assign n_data = {7'b0, i_result.pulses, i_result.anomaly_count,
                     i_result.read_pending, i_result.mode_lines, i_result.mode_valid,
                     i_result.read_mode, i_result.error_line, i_result.reader_free,
                     i_result.end_of_card, i_result.data_lines, i_result.char_strobe};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_room) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/card_reader_interface_unit.sv
// Card reader interface, top level. A result passes the input register, then the
// result register, before it is offered on the master stream. Throughput: one item
// per cycle while the master stream does not stall, set by the line state update.
// Reset (synchronous, active low) clears all reader lines, the mode latch,
// the anomaly counter and the not-operable register; both stages come up empty.
// Depends on cri_pkg, cri_in_stage, cri_core, cri_out_stage.
module card_reader_interface_unit #(
    parameter int ANOMALY_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [cri_pkg::TDATA_IN_BITS-1:0]    s_axis_tdata,  // command_byte, data_byte
    input  logic [2:0]                           s_axis_tuser,  // opcode
    input  logic                                 s_axis_tlast,  // end_flag
    // master stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // char_strobe, data_lines, end_of_card, reader_free, error_line, read_mode,
    // mode_valid, mode_lines, read_pending, anomaly_count, pulses, zero fill
    output logic [cri_pkg::TDATA_OUT_BITS-1:0]   m_axis_tdata,
    // configuration write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_data     // not_operable
);
    import cri_pkg::*;

    t_item   in_item;
    t_item   st_item;
    t_result result;
    logic    st_valid;
    logic    out_room;
    logic    fire;
    logic    r_not_operable;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_not_operable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_not_operable <= i_cfg_data;
        end
    end

    assign in_item.opcode       = s_axis_tuser;
    assign in_item.command_byte = s_axis_tdata[7:0];
    assign in_item.data_byte    = s_axis_tdata[15:8];
    assign in_item.end_flag     = s_axis_tlast;

    // held item moves on when the result register has room
    assign fire = st_valid && out_room;

    cri_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (in_item),
        .o_ready (s_axis_tready),
        .i_take  (fire),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    cri_core #(
        .ANOMALY_BITS (ANOMALY_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (st_item),
        .i_not_operable (r_not_operable),
        .o_result       (result)
    );

    cri_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (st_valid),
        .i_result (result),
        .o_room   (out_room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule
